### sv/gpc_pkg.sv
// shared types, event codes and button layout for the gamepad poll conditioner
`timescale 1ns / 1ps

package gpc_pkg;

    localparam int NUM_BUTTONS = 14;
    localparam int NUM_ANALOG  = 6;

    // q1.15 full scale
    localparam logic [14:0] FULL_SCALE = 15'd32767;

    // event codes
    localparam logic [4:0] EV_BTN_LAST   = 5'd13;
    localparam logic [4:0] EV_AXIS_BASE  = 5'd14;
    localparam logic [4:0] EV_RTRIG      = 5'd19;

    // analog channel index of the right trigger
    localparam logic [2:0] CH_RTRIG      = 3'd5;
    localparam logic [2:0] CH_LTRIG      = 3'd4;

    localparam logic [14:0] TRIG_DIVISOR = 15'd255;
    localparam logic [30:0] TRIG_ROUND   = 31'd127;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [30:0] num;
        logic [14:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quot;
    } div_resp_t;

    // bit position of each button in the button word, in event order
    function automatic logic [3:0] button_bit(input logic [3:0] idx);
        logic [3:0] pos;
        unique case (idx)
            4'd0:    pos = 4'd12;  // a
            4'd1:    pos = 4'd13;  // b
            4'd2:    pos = 4'd14;  // x
            4'd3:    pos = 4'd15;  // y
            4'd4:    pos = 4'd0;   // up
            4'd5:    pos = 4'd1;   // down
            4'd6:    pos = 4'd2;   // left
            4'd7:    pos = 4'd3;   // right
            4'd8:    pos = 4'd6;   // left thumb
            4'd9:    pos = 4'd7;   // right thumb
            4'd10:   pos = 4'd5;   // back
            4'd11:   pos = 4'd4;   // start
            4'd12:   pos = 4'd8;   // left shoulder
            4'd13:   pos = 4'd9;   // right shoulder
            default: pos = 4'd10;  // unused bit
        endcase
        return pos;
    endfunction

endpackage

### sv/gpc_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module gpc_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  gpc_pkg::div_req_t   req,
    output gpc_pkg::div_resp_t  resp
);

    // quotient must fit in 16 bits: num < den * 2^16
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [14:0] rem_reg, rem_next;
    logic [15:0] low_reg, low_next;
    logic [14:0] den_reg, den_next;

    logic [15:0] trial;
    logic        fits;

    always_comb
    begin
        trial     = {rem_reg, low_reg[15]};
        fits      = (trial >= {1'b0, den_reg});
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            cnt_next = 5'd16;
            rem_next = req.num[30:16];
            low_next = req.num[15:0];
            den_next = req.den;
        end
        else if (cnt_reg != 5'd0)
        begin
            cnt_next  = cnt_reg - 5'd1;
            done_next = (cnt_reg == 5'd1);
            rem_next  = fits ? 15'(trial - {1'b0, den_reg}) : trial[14:0];
            low_next  = {low_reg[14:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign resp.busy = (cnt_reg != 5'd0);
    assign resp.done = done_reg;
    assign resp.quot = low_reg;

endmodule

### sv/gamepad_poll_conditioner_top.sv
// gamepad poll conditioner: button edge events, stick deadzone and trigger scaling
// sequence: after the poll transfer the buttons are scanned, each changed one loaded into
//   the output register, then each analog channel has a setup step, a run of the shared
//   16-step divider and a step to write the event
// one poll at a time, taken only in idle; a stick inside the deadzone skips the divider
// reset: rst_n is asynchronous, clears the stored button words and the deadzone to zero
`timescale 1ns / 1ps

module gamepad_poll_conditioner_top
#(
    parameter int PORTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration: stick deadzone, q0.15
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,

    // poll input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // buttons[15:0], left_stick_x[31:16], left_stick_y[47:32],
    // right_stick_x[63:48], right_stick_y[79:64], left_trigger[87:80],
    // right_trigger[95:88]
    input  logic [95:0] s_axis_tdata,
    // port[1:0]
    input  logic [1:0]  s_axis_tuser,

    // event output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_value[15:0]
    output logic [15:0] m_axis_tdata,
    // event_code[4:0], event_port[6:5]
    output logic [6:0]  m_axis_tuser,
    // last_event
    output logic        m_axis_tlast
);

    localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_BTN   = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  bidx_reg, bidx_next;     // button scan index
    logic [2:0]  kidx_reg, kidx_next;     // analog channel index
    logic [14:0] dz_reg;

    // poll held for the whole sequence
    logic [1:0]  port_reg;
    logic [15:0] now_reg;
    logic [15:0] before_reg;
    logic [15:0] axis_reg [4];
    logic [7:0]  trig_reg [2];
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;

    // last button word per port
    logic [15:0] last_buttons_reg [PORTS];

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [4:0]  m_code_reg;
    logic [1:0]  m_port_reg;
    logic [15:0] m_value_reg;
    logic        m_last_reg;

    logic        out_load;
    logic [4:0]  out_code;
    logic [15:0] out_value;
    logic        out_last;
    logic        out_free;

    logic        accept;
    logic        port_ok;
    logic [PIDX_W-1:0] pidx;

    // button scan
    logic [3:0]  bpos;
    logic        bchanged;

    // analog setup
    logic [15:0] raw;
    logic [15:0] mag16;
    logic [14:0] mag;
    logic [14:0] span;
    logic [14:0] diff;
    logic [7:0]  trig;
    logic        setup_neg;
    logic        setup_zero;
    logic [30:0] setup_num;
    logic [14:0] setup_den;

    // divider result
    logic [14:0] qclamp;
    logic [15:0] qsigned;

    gpc_pkg::div_req_t  div_req;
    gpc_pkg::div_resp_t div_resp;

    gpc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign port_ok       = (32'(s_axis_tuser) < PORTS);
    assign pidx          = PIDX_W'(s_axis_tuser);
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign bpos     = gpc_pkg::button_bit(bidx_reg);
    assign bchanged = now_reg[bpos] ^ before_reg[bpos];

    // analog channel setup: magnitude, deadzone test and divider operands
    always_comb
    begin
        raw        = axis_reg[kidx_reg[1:0]];
        trig       = trig_reg[kidx_reg[0]];
        mag16      = raw[15] ? 16'(-raw) : raw;
        // -32768 clamps to -1.0
        mag        = mag16[15] ? gpc_pkg::FULL_SCALE : mag16[14:0];
        span       = gpc_pkg::FULL_SCALE - dz_reg;
        diff       = mag - dz_reg;
        if (kidx_reg < gpc_pkg::CH_LTRIG)
        begin
            setup_neg  = raw[15];
            setup_zero = (mag <= dz_reg);
            // diff * 32767 + span / 2
            setup_num  = (31'(diff) << 15) - 31'(diff) + 31'(span[14:1]);
            setup_den  = span;
        end
        else
        begin
            setup_neg  = 1'b0;
            setup_zero = 1'b0;
            // t * 32767 + 127 over 255 rounds to nearest
            setup_num  = (31'(trig) << 15) - 31'(trig) + gpc_pkg::TRIG_ROUND;
            setup_den  = gpc_pkg::TRIG_DIVISOR;
        end
    end

    assign div_req.start = (state_reg == ST_LOAD) && !setup_zero;
    assign div_req.num   = setup_num;
    assign div_req.den   = setup_den;

    assign qclamp  = div_resp.quot[15] ? gpc_pkg::FULL_SCALE : div_resp.quot[14:0];
    assign qsigned = neg_reg ? 16'(-{1'b0, qclamp}) : {1'b0, qclamp};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        bidx_next  = bidx_reg;
        kidx_next  = kidx_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        out_load   = 1'b0;
        out_code   = 5'(bidx_reg);
        out_value  = 16'd0;
        out_last   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                bidx_next = 4'd0;
                kidx_next = 3'd0;
                // polls of ports beyond the table are dropped
                if (accept && port_ok)
                begin
                    state_next = ST_BTN;
                end
            end
            ST_BTN:
            begin
                // one button per cycle; a changed button waits for a free output
                if (!bchanged || out_free)
                begin
                    out_load  = bchanged;
                    out_code  = 5'(bidx_reg);
                    out_value = now_reg[bpos] ? {1'b0, gpc_pkg::FULL_SCALE} : 16'd0;
                    if (5'(bidx_reg) == gpc_pkg::EV_BTN_LAST)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        bidx_next = bidx_reg + 4'd1;
                    end
                end
            end
            ST_LOAD:
            begin
                neg_next   = setup_neg;
                zero_next  = setup_zero;
                state_next = setup_zero ? ST_WRITE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_resp.done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    out_code  = gpc_pkg::EV_AXIS_BASE + 5'(kidx_reg);
                    out_value = zero_reg ? 16'd0 : qsigned;
                    out_last  = (kidx_reg == gpc_pkg::CH_RTRIG);
                    if (kidx_reg == gpc_pkg::CH_RTRIG)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        kidx_next  = kidx_reg + 3'd1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else
        begin
            m_valid_next = m_valid_reg && !m_axis_tready;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bidx_reg    <= 4'd0;
            kidx_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
            dz_reg      <= 15'd0;
        end
        else
        begin
            state_reg   <= state_next;
            bidx_reg    <= bidx_next;
            kidx_reg    <= kidx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                dz_reg <= cfg_wdata;
            end
        end
    end

    // stored button words; the new word replaces the old one at the poll transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                last_buttons_reg[i] <= 16'd0;
            end
        end
        else if (accept && port_ok)
        begin
            last_buttons_reg[pidx] <= s_axis_tdata[15:0];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        if (accept && port_ok)
        begin
            port_reg    <= s_axis_tuser;
            now_reg     <= s_axis_tdata[15:0];
            before_reg  <= last_buttons_reg[pidx];
            axis_reg[0] <= s_axis_tdata[31:16];
            axis_reg[1] <= s_axis_tdata[47:32];
            axis_reg[2] <= s_axis_tdata[63:48];
            axis_reg[3] <= s_axis_tdata[79:64];
            trig_reg[0] <= s_axis_tdata[87:80];
            trig_reg[1] <= s_axis_tdata[95:88];
        end
        if (out_load)
        begin
            m_code_reg  <= out_code;
            m_port_reg  <= port_reg;
            m_value_reg <= out_value;
            m_last_reg  <= out_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_value_reg;
    assign m_axis_tuser  = {m_port_reg, m_code_reg};
    assign m_axis_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // only the right trigger event closes a poll
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[4:0] == gpc_pkg::EV_RTRIG)
        else $error("last flag on an event other than the right trigger");

    // the divider is never left running when a new poll can enter
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !div_resp.busy)
        else $error("divider busy while idle");

    // a poll of a valid port keeps the input closed for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && port_ok |=> !s_axis_tready)
        else $error("input still open after a poll transfer");

    // values are symmetric: -1.0 is -32767, never the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata != 16'h8000)
        else $error("event value out of q1.15 range");

    // a divider result is only awaited after a start
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> div_resp.busy || div_resp.done)
        else $error("waiting on an idle divider");
`endif

endmodule

### dv/testbench.sv
// self-checking testbench for the gamepad poll conditioner top level
`timescale 1ns / 1ps

module testbench;

    // run ends as failed if it is still going after this many cycles
    localparam int CYCLE_LIMIT = 1_000_000;

    // left trigger sits just below the right trigger in the event code space
    localparam logic [4:0] EV_LTRIG = gpc_pkg::EV_RTRIG - 5'd1;

    // bit of the button word behind each button event code, code 0 in the low nibble
    localparam logic [13:0][3:0] BTN_POS = {
        4'd9, 4'd8, 4'd4, 4'd5, 4'd7, 4'd6, 4'd3,
        4'd2, 4'd1, 4'd0, 4'd15, 4'd14, 4'd13, 4'd12
    };

    // one poll as the sender sees it; axis[0..3] = lx, ly, rx, ry; trig[0] = left
    typedef struct packed {
        logic [1:0]        port;
        logic [15:0]       buttons;
        logic [3:0][15:0]  axis;
        logic [1:0][7:0]   trig;
    } poll_t;

    // one event as it leaves the block
    typedef struct packed {
        logic [4:0]  code;
        logic [1:0]  port;
        logic [15:0] value;
        logic        last;
    } evt_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [14:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [6:0]  m_axis_tuser;
    logic        m_axis_tlast;

    gamepad_poll_conditioner_top #(
        .PORTS (4)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // polls waiting to be sent, front is the one on the bus
    poll_t       poll_q[$];
    // events predicted but not yet seen on the output
    evt_t        due_events[$];

    // predictor state: stored button word per port and the deadzone in force
    logic [15:0] held_buttons [4];
    logic [14:0] deadzone_shadow;
    // button words as the stimulus generator last queued them per port
    logic [15:0] queued_buttons [4];

    // idling on both sides only while this is set
    bit          noisy = 1'b0;
    // poll transfer seen at the last rising edge
    bit          taken = 1'b0;
    int          send_gap = 0;
    int          sink_gap = 0;
    int          cycle_count = 0;
    int          fault_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // clamp to full scale, apply the axial deadzone and rescale the remainder
    function automatic logic [15:0] condition_axis(input logic [15:0] raw,
                                                   input logic [14:0] dz);
        longint      mag;
        longint      span;
        longint      q;
        longint      d;
        logic [15:0] qv;
        d   = longint'(dz);
        mag = raw[15] ? 65536 - longint'(raw) : longint'(raw);
        if (mag > longint'(gpc_pkg::FULL_SCALE))
            mag = longint'(gpc_pkg::FULL_SCALE);
        // covers the zero axis at zero deadzone and the full-scale deadzone
        if (mag <= d)
            return 16'd0;
        span = longint'(gpc_pkg::FULL_SCALE) - d;
        q    = ((mag - d) * longint'(gpc_pkg::FULL_SCALE) + span / 2) / span;
        if (q > longint'(gpc_pkg::FULL_SCALE))
            q = longint'(gpc_pkg::FULL_SCALE);
        qv = q[15:0];
        return raw[15] ? (~qv + 16'd1) : qv;
    endfunction

    // trigger / 255 rounded to nearest, on the q1.15 scale
    function automatic logic [15:0] scale_trigger(input logic [7:0] t);
        int unsigned v;
        v = (int'(t) * int'(gpc_pkg::FULL_SCALE) + 127) / 255;
        return v[15:0];
    endfunction

    // queue up every event that one accepted poll causes
    task automatic derive_events(input poll_t p);
        logic [15:0] prior;
        evt_t        e;
        int          i;
        prior  = held_buttons[p.port];
        e.port = p.port;
        e.last = 1'b0;
        for (i = 0; i < gpc_pkg::NUM_BUTTONS; i++)
        begin
            if (p.buttons[BTN_POS[i]] != prior[BTN_POS[i]])
            begin
                e.code  = i[4:0];
                e.value = p.buttons[BTN_POS[i]] ? {1'b0, gpc_pkg::FULL_SCALE} : 16'd0;
                due_events.push_back(e);
            end
        end
        for (i = 0; i < 4; i++)
        begin
            e.code  = gpc_pkg::EV_AXIS_BASE + i[4:0];
            e.value = condition_axis(p.axis[i], deadzone_shadow);
            due_events.push_back(e);
        end
        e.code  = EV_LTRIG;
        e.value = scale_trigger(p.trig[0]);
        due_events.push_back(e);
        e.code  = gpc_pkg::EV_RTRIG;
        e.value = scale_trigger(p.trig[1]);
        e.last  = 1'b1;
        due_events.push_back(e);
        // the whole word is kept, unused bits too
        held_buttons[p.port] = p.buttons;
    endtask

    task automatic flag_mismatch(input string what, input evt_t want, input evt_t got);
        fault_count++;
        if (fault_count <= 10)
            $display({"%0t ns: %s: expected code %0d port %0d value %0d last %0d,",
                      " got code %0d port %0d value %0d last %0d"},
                     $time, what, want.code, want.port, $signed(want.value), want.last,
                     got.code, got.port, $signed(got.value), got.last);
    endtask

    // ------------------------------------------------------------------
    // monitor: transfers on both sides are taken at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        evt_t  want;
        evt_t  got;
        poll_t p;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                taken = s_axis_tvalid && s_axis_tready;
                if (taken)
                begin
                    p = poll_q.pop_front();
                    derive_events(p);
                end
                if (m_axis_tvalid && m_axis_tready)
                begin
                    got.code  = m_axis_tuser[4:0];
                    got.port  = m_axis_tuser[6:5];
                    got.value = m_axis_tdata;
                    got.last  = m_axis_tlast;
                    if (due_events.size() == 0)
                    begin
                        want = '0;
                        flag_mismatch("event with none pending", want, got);
                    end
                    else
                    begin
                        want = due_events.pop_front();
                        if (got.code !== want.code || got.port !== want.port ||
                            got.value !== want.value || got.last !== want.last)
                            flag_mismatch("event mismatch", want, got);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // poll driver: changes at the falling edge, holds a poll until its transfer
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !taken)
            begin
                // still waiting for the transfer, keep everything steady
            end
            else if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end
            else if (poll_q.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (noisy && $urandom_range(0, 5) == 0)
            begin
                // start an idle burst, its remaining length drawn at random into send_gap
                s_axis_tvalid <= 1'b0;
                send_gap = $urandom_range(0, 15);
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {poll_q[0].trig, poll_q[0].axis, poll_q[0].buttons};
                s_axis_tuser  <= poll_q[0].port;
            end
        end
    end

    // ------------------------------------------------------------------
    // event sink: ready stalls in bursts while noisy
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_gap--;
            end
            else if (noisy && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                sink_gap = $urandom_range(0, 15);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic add_poll(input int port_n, input int btn, input int lx, input int ly,
                            input int rx, input int ry, input int lt, input int rt);
        poll_t p;
        p.port    = port_n[1:0];
        p.buttons = btn[15:0];
        p.axis[0] = lx[15:0];
        p.axis[1] = ly[15:0];
        p.axis[2] = rx[15:0];
        p.axis[3] = ry[15:0];
        p.trig[0] = lt[7:0];
        p.trig[1] = rt[7:0];
        queued_buttons[p.port] = p.buttons;
        poll_q.push_back(p);
    endtask

    // sender pauses here until the block has delivered every pending event
    task automatic drain;
        while (poll_q.size() != 0 || due_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // only called while the block is idle
    task automatic set_deadzone(input int dz);
        @(negedge clk);
        cfg_we          <= 1'b1;
        cfg_wdata       <= dz[14:0];
        deadzone_shadow  = dz[14:0];
        @(negedge clk);
        cfg_we          <= 1'b0;
    endtask

    // axis value weighted toward full scale, the deadzone edge and the origin
    function automatic int random_axis(input int dz);
        int mag;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            return $urandom_range(0, 65535);
        if (pick <= 5)
            mag = dz + $urandom_range(0, 4) - 2;
        else if (pick == 6)
        begin
            case ($urandom_range(0, 4))
                0:       return -32768;
                1:       return 32767;
                2:       return -1;
                3:       return 1;
                default: return 0;
            endcase
        end
        else
            mag = $urandom_range(0, (2 * dz + 8 > 32767) ? 32767 : 2 * dz + 8);
        if (mag < 0)
            mag = 0;
        if (mag > 32767)
            mag = 32767;
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic int random_trigger;
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // mostly a few buttons flipped from the word last queued on that port
    task automatic add_random_poll;
        int          port_n;
        logic [15:0] w;
        port_n = $urandom_range(0, 3);
        w      = queued_buttons[port_n];
        if ($urandom_range(0, 3) != 0)
        begin
            repeat ($urandom_range(0, 3))
                w[$urandom_range(0, 15)] ^= 1'b1;
        end
        else
            w = 16'($urandom_range(0, 65535));
        add_poll(port_n, w, random_axis(deadzone_shadow), random_axis(deadzone_shadow),
                 random_axis(deadzone_shadow), random_axis(deadzone_shadow),
                 random_trigger(), random_trigger());
    endtask

    initial
    begin
        int phase;
        int dz;
        int k;
        for (k = 0; k < 4; k++)
        begin
            held_buttons[k]   = '0;
            queued_buttons[k] = '0;
        end
        deadzone_shadow = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed polls at the reset deadzone of zero
        noisy = 1'b1;
        add_poll(0, 'h0000, 0, 0, 0, 0, 0, 0);                // zero axes at zero deadzone
        add_poll(0, 'hFFFF, -32768, 32767, -1, 1, 255, 0);    // every button pressed
        add_poll(0, 'h0000, 32767, -32768, 1, -1, 0, 255);    // every button released
        add_poll(1, 'h0C00, 16384, -16384, 100, -100, 1, 254); // unused bits only
        add_poll(1, 'h0000, -32767, 2, -2, 0, 128, 127);      // unused bits cleared again
        add_poll(2, 'hAAAA, 12345, -12345, 32766, -32766, 3, 252);
        add_poll(2, 'h5555, -20000, 20000, 7, -7, 254, 1);
        add_poll(3, 'h1234, 0, -32768, 32767, 0, 64, 191);
        drain();

        // full-scale deadzone silences every stick
        set_deadzone(32767);
        add_poll(3, 'hEDCB, -32768, 32767, 0, 1, 10, 20);
        add_poll(0, 'h3C0F, 32767, -32767, -1, 16384, 30, 40);
        drain();

        set_deadzone(32766);
        add_poll(0, 'h0000, 32767, -32767, -32768, 32766, 50, 60);
        add_poll(1, 'hF3FF, -32766, 32765, 0, -32768, 70, 80);
        drain();

        // axis exactly at the deadzone and one step past it
        set_deadzone(16384);
        add_poll(1, 'h0400, 16384, 16385, -16384, -16385, 90, 100);
        add_poll(2, 'h0800, 16383, -16383, 0, 32767, 110, 120);
        drain();

        set_deadzone(1);
        add_poll(0, 'h0001, 1, -1, 2, -2, 130, 140);
        add_poll(3, 'h8000, 0, -32768, 32767, 3, 150, 160);
        drain();

        // random phases across several deadzone settings, the last one without idling
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       dz = 0;
                1:       dz = $urandom_range(1, 32766);
                2:       dz = 32766;
                3:       dz = $urandom_range(0, 1000);
                4:       dz = 32767;
                default: dz = $urandom_range(0, 32767);
            endcase
            set_deadzone(dz);
            noisy = (phase != 5);
            repeat (59)
                add_random_poll();
            drain();
        end

        repeat (150) @(posedge clk);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### gamepad_poll_conditioner_top.f
sv/gpc_pkg.sv
sv/gpc_div.sv
sv/gamepad_poll_conditioner_top.sv
dv/testbench.sv
